FILE: src/mtd_pkg.sv
// Shared types and constants of the market tick dedup filter.
`timescale 1ns / 1ps

package mtd_pkg;

    // Field widths of the input and result beats.
    localparam int CFG_W      = 7;
    localparam int MODE_W     = 2;
    localparam int ID_FIELD_W = 64;
    localparam int SLOT_W     = 6;
    localparam int TIME_W     = 64;
    localparam int MS_W       = 10;
    localparam int PRICE_W    = 48;
    localparam int STATUS_W   = 3;
    localparam int KEY_W      = 32;

    // Item modes. Code 3 is unused and handled like a control item.
    localparam logic [MODE_W-1:0] MODE_TICK  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd1;
    localparam logic [MODE_W-1:0] MODE_LOAD  = 2'd2;

    // Weights of the six time digits in the key HH*10^7 + MM*10^5 + SS*1000.
    localparam logic [KEY_W-1:0] W_HOUR_TENS = 32'd100000000;
    localparam logic [KEY_W-1:0] W_HOUR      = 32'd10000000;
    localparam logic [KEY_W-1:0] W_MIN_TENS  = 32'd1000000;
    localparam logic [KEY_W-1:0] W_MIN       = 32'd100000;
    localparam logic [KEY_W-1:0] W_SEC_TENS  = 32'd10000;
    localparam logic [KEY_W-1:0] W_SEC       = 32'd1000;

    typedef enum logic [STATUS_W-1:0] {
        ST_FORWARDED = 3'd0,
        ST_BAD_PRICE = 3'd1,
        ST_UNKNOWN   = 3'd2,
        ST_STALE     = 3'd3,
        ST_CONTROL   = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_LOAD,
        S_ZERO,
        S_SCAN,
        S_KRD,
        S_KCHK,
        S_RESULT
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    accept;
        logic    load_write;
        logic    scan_step;
        logic    zero_step;
        logic    key_update;
        logic    res_set;
        t_status res_code;
        logic    res_match;
        logic    out_load;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic price_ok;
        logic hit;
        logic scan_over;
        logic zero_over_n;
        logic zero_over_all;
        logic stale;
        logic out_free;
    } t_stat;

endpackage

FILE: src/mtd_tick_if.sv
// Input channel of the market tick dedup filter: one tick or control item per beat.
`timescale 1ns / 1ps

interface mtd_tick_if;
    logic                                   valid;
    logic                                   ready;
    logic        [mtd_pkg::MODE_W-1:0]      mode;
    logic        [mtd_pkg::ID_FIELD_W-1:0]  instrument_id;
    logic        [mtd_pkg::SLOT_W-1:0]      slot;
    logic        [mtd_pkg::TIME_W-1:0]      time_text;
    logic        [mtd_pkg::MS_W-1:0]        millisecond;
    logic signed [mtd_pkg::PRICE_W-1:0]     trade_price;
    logic signed [mtd_pkg::PRICE_W-1:0]     upper_limit;
    logic signed [mtd_pkg::PRICE_W-1:0]     lower_limit;

    modport source (
        output valid, mode, instrument_id, slot, time_text, millisecond,
               trade_price, upper_limit, lower_limit,
        input  ready
    );

    modport sink (
        input  valid, mode, instrument_id, slot, time_text, millisecond,
               trade_price, upper_limit, lower_limit,
        output ready
    );
endinterface

FILE: src/mtd_result_if.sv
// Result channel of the market tick dedup filter: one result per beat.
`timescale 1ns / 1ps

interface mtd_result_if;
    logic                               valid;
    logic                               ready;
    logic                               forwarded;
    logic        [mtd_pkg::STATUS_W-1:0] status;
    logic        [mtd_pkg::SLOT_W-1:0]   matched_slot;
    logic signed [mtd_pkg::KEY_W-1:0]    time_key;

    modport source (
        output valid, forwarded, status, matched_slot, time_key,
        input  ready
    );

    modport sink (
        input  valid, forwarded, status, matched_slot, time_key,
        output ready
    );
endinterface

FILE: src/market_tick_dedup_filter_core.sv
// Top level of the market tick dedup filter.
`timescale 1ns / 1ps

// The filter takes one beat at a time on i_tick and returns exactly one result beat
// on o_result for it. A load beat writes an instrument id (cut to ID_CHARS characters
// and ending at the first zero byte) into a table slot and zeroes that slot's
// last-seen time key; a clear beat zeroes the keys of the first instruments_in_use
// slots after a feed disconnect; a tick beat is checked for a positive price within
// its positive limits, looked up among the slots in use (first match wins), given
// the key HH*10^7 + MM*10^5 + SS*1000 + ms, and forwarded unless a nonzero key is not
// newer than the one stored for that instrument. The instrument table is a memory
// with one read port and is searched one slot per cycle. A tick with a bad price goes
// straight to its result, a tick that matches reads and checks the stored key of its
// slot, an unknown instrument is reported once all n slots in use are searched and a
// clear zeroes n keys, where n is the saturated instruments_in_use. The result
// sits in an output register, so a beat can be accepted while the previous result
// still waits on o_result. After reset a clearing pass zeroes the whole key table,
// which keeps i_tick not ready until it is done; configuration writes are taken
// throughout. Slots that were never loaded hold unknown ids and must not be
// searched.

module market_tick_dedup_filter_core #(
    parameter int TABLE_SLOTS = 64,
    parameter int ID_CHARS    = 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [mtd_pkg::CFG_W-1:0]     i_cfg_wdata,
    mtd_tick_if.sink                      i_tick,
    mtd_result_if.source                  o_result
);

    mtd_pkg::t_cmd  w_cmd;
    mtd_pkg::t_stat w_stat;
    logic           w_in_ready;

    // The controller sequences each beat; the datapath holds the tables and the math.
    mtd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_tick.valid),
        .i_in_mode  (i_tick.mode),
        .o_in_ready (w_in_ready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    mtd_datapath #(
        .TABLE_SLOTS (TABLE_SLOTS),
        .ID_CHARS    (ID_CHARS)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_stat          (w_stat),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_mode          (i_tick.mode),
        .i_instrument_id (i_tick.instrument_id),
        .i_slot          (i_tick.slot),
        .i_time_text     (i_tick.time_text),
        .i_millisecond   (i_tick.millisecond),
        .i_trade_price   (i_tick.trade_price),
        .i_upper_limit   (i_tick.upper_limit),
        .i_lower_limit   (i_tick.lower_limit),
        .o_out_valid     (o_result.valid),
        .i_out_ready     (o_result.ready),
        .o_forwarded     (o_result.forwarded),
        .o_status        (o_result.status),
        .o_matched_slot  (o_result.matched_slot),
        .o_time_key      (o_result.time_key)
    );

    assign i_tick.ready = w_in_ready;

    // The key clearing pass after reset holds off input beats.
    a_reset_holds_input: assert property (
        @(posedge i_clk) !i_rst_n |=> !i_tick.ready
    ) else $error("input ready right after reset");

    // Only one beat is in the block at a time.
    a_one_beat_at_a_time: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (i_tick.valid && i_tick.ready) |=> !i_tick.ready
    ) else $error("input accepted while a beat is in work");

    // Handing a result to the output register frees the block for the next beat.
    a_result_frees_input: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.out_load |=> i_tick.ready
    ) else $error("block not ready after its result was loaded");

    // Only a matched instrument reports a slot.
    a_slot_only_on_match: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_result.valid && (o_result.status != mtd_pkg::ST_FORWARDED)
            && (o_result.status != mtd_pkg::ST_STALE))
        |-> (o_result.matched_slot == '0)
    ) else $error("slot reported without an instrument match");

endmodule

FILE: src/mtd_ctrl.sv
// Controller state machine of the market tick dedup filter.
`timescale 1ns / 1ps

module mtd_ctrl (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    input  logic [mtd_pkg::MODE_W-1:0]   i_in_mode,
    output logic                         o_in_ready,
    input  mtd_pkg::t_stat               i_stat,
    output mtd_pkg::t_cmd                o_cmd
);

    mtd_pkg::t_state r_state;
    mtd_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mtd_pkg::S_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            mtd_pkg::S_INIT: begin
                if (i_stat.zero_over_all) begin
                    n_state = mtd_pkg::S_IDLE;
                end
            end
            mtd_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    unique case (i_in_mode)
                        mtd_pkg::MODE_TICK:  n_state = mtd_pkg::S_SCAN;
                        mtd_pkg::MODE_CLEAR: n_state = mtd_pkg::S_ZERO;
                        mtd_pkg::MODE_LOAD:  n_state = mtd_pkg::S_LOAD;
                        default:             n_state = mtd_pkg::S_RESULT;
                    endcase
                end
            end
            mtd_pkg::S_LOAD: begin
                n_state = mtd_pkg::S_RESULT;
            end
            mtd_pkg::S_ZERO: begin
                if (i_stat.zero_over_n) begin
                    n_state = mtd_pkg::S_RESULT;
                end
            end
            mtd_pkg::S_SCAN: begin
                if (!i_stat.price_ok || i_stat.scan_over) begin
                    n_state = mtd_pkg::S_RESULT;
                end else if (i_stat.hit) begin
                    n_state = mtd_pkg::S_KRD;
                end
            end
            mtd_pkg::S_KRD: begin
                n_state = mtd_pkg::S_KCHK;
            end
            mtd_pkg::S_KCHK: begin
                n_state = mtd_pkg::S_RESULT;
            end
            mtd_pkg::S_RESULT: begin
                if (i_stat.out_free) begin
                    n_state = mtd_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = mtd_pkg::S_INIT;
            end
        endcase
    end

    // Commands.
    always_comb begin
        o_cmd          = '0;
        o_cmd.res_code = mtd_pkg::ST_CONTROL;
        o_in_ready     = (r_state == mtd_pkg::S_IDLE);
        unique case (r_state)
            mtd_pkg::S_INIT: begin
                o_cmd.zero_step = !i_stat.zero_over_all;
            end
            mtd_pkg::S_IDLE: begin
                // Every item starts out as a control result; ticks overwrite it.
                o_cmd.accept  = i_in_valid;
                o_cmd.res_set = i_in_valid;
            end
            mtd_pkg::S_LOAD: begin
                o_cmd.load_write = 1'b1;
            end
            mtd_pkg::S_ZERO: begin
                o_cmd.zero_step = !i_stat.zero_over_n;
            end
            mtd_pkg::S_SCAN: begin
                if (!i_stat.price_ok) begin
                    o_cmd.res_set  = 1'b1;
                    o_cmd.res_code = mtd_pkg::ST_BAD_PRICE;
                end else if (i_stat.hit) begin
                    o_cmd.scan_step = 1'b0;
                end else if (i_stat.scan_over) begin
                    o_cmd.res_set  = 1'b1;
                    o_cmd.res_code = mtd_pkg::ST_UNKNOWN;
                end else begin
                    o_cmd.scan_step = 1'b1;
                end
            end
            mtd_pkg::S_KRD: begin
                o_cmd.res_match = 1'b0;
            end
            mtd_pkg::S_KCHK: begin
                o_cmd.res_set   = 1'b1;
                o_cmd.res_match = 1'b1;
                if (i_stat.stale) begin
                    o_cmd.res_code = mtd_pkg::ST_STALE;
                end else begin
                    o_cmd.res_code   = mtd_pkg::ST_FORWARDED;
                    o_cmd.key_update = 1'b1;
                end
            end
            mtd_pkg::S_RESULT: begin
                o_cmd.out_load = i_stat.out_free;
            end
            default: begin
                o_cmd.out_load = 1'b0;
            end
        endcase
    end

endmodule

FILE: src/mtd_datapath.sv
// Datapath of the market tick dedup filter: tables, key arithmetic and result register.
`timescale 1ns / 1ps

module mtd_datapath #(
    parameter int TABLE_SLOTS = 64,
    parameter int ID_CHARS    = 8
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  mtd_pkg::t_cmd                        i_cmd,
    output mtd_pkg::t_stat                       o_stat,
    input  logic                                 i_cfg_we,
    input  logic        [mtd_pkg::CFG_W-1:0]      i_cfg_wdata,
    input  logic        [mtd_pkg::MODE_W-1:0]     i_mode,
    input  logic        [mtd_pkg::ID_FIELD_W-1:0] i_instrument_id,
    input  logic        [mtd_pkg::SLOT_W-1:0]     i_slot,
    input  logic        [mtd_pkg::TIME_W-1:0]     i_time_text,
    input  logic        [mtd_pkg::MS_W-1:0]       i_millisecond,
    input  logic signed [mtd_pkg::PRICE_W-1:0]    i_trade_price,
    input  logic signed [mtd_pkg::PRICE_W-1:0]    i_upper_limit,
    input  logic signed [mtd_pkg::PRICE_W-1:0]    i_lower_limit,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic                                 o_forwarded,
    output logic        [mtd_pkg::STATUS_W-1:0]   o_status,
    output logic        [mtd_pkg::SLOT_W-1:0]     o_matched_slot,
    output logic signed [mtd_pkg::KEY_W-1:0]      o_time_key
);

    localparam int IDX_W = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
    localparam int CNT_W = $clog2(TABLE_SLOTS + 1);
    localparam int ID_W  = 8 * ID_CHARS;
    localparam int CMP_W = (CNT_W > mtd_pkg::CFG_W) ? CNT_W : mtd_pkg::CFG_W;
    localparam int SEL_W = mtd_pkg::SLOT_W + IDX_W;
    localparam logic [CNT_W-1:0] SLOTS_CNT = CNT_W'(TABLE_SLOTS);
    localparam logic [CMP_W-1:0] SLOTS_CMP = CMP_W'(TABLE_SLOTS);
    localparam logic [SEL_W-1:0] SLOTS_SEL = SEL_W'(TABLE_SLOTS);
    localparam logic signed [8:0] ASCII_ZERO = 9'sd48;

    // One time character times its weight, wrapped to the key width.
    function automatic logic [mtd_pkg::KEY_W-1:0] char_term(
        input logic [7:0]                  ch,
        input logic [mtd_pkg::KEY_W-1:0]   weight
    );
        logic signed [8:0]                  digit;
        logic signed [mtd_pkg::KEY_W-1:0]   digit_ext;
        digit     = $signed({1'b0, ch}) - ASCII_ZERO;
        digit_ext = mtd_pkg::KEY_W'(digit);
        return mtd_pkg::KEY_W'(digit_ext * $signed(weight));
    endfunction

    logic [ID_W-1:0]          id_mem  [TABLE_SLOTS];
    logic [mtd_pkg::KEY_W-1:0] key_mem [TABLE_SLOTS];

    // Configuration.
    logic [CMP_W-1:0] cfg_ext;
    logic [CNT_W-1:0] n_slots_in_use;
    logic [CNT_W-1:0] r_slots_in_use;

    // Item registers.
    logic [mtd_pkg::MODE_W-1:0]  r_mode;
    logic [ID_W-1:0]             r_id_norm;
    logic                        r_slot_ok;
    logic [IDX_W-1:0]            r_slot_idx;
    logic                        r_price_ok;
    logic [mtd_pkg::KEY_W-1:0]   r_term_hh;
    logic [mtd_pkg::KEY_W-1:0]   r_term_mm;
    logic [mtd_pkg::KEY_W-1:0]   r_term_ss;
    logic [mtd_pkg::MS_W-1:0]    r_ms;
    logic [mtd_pkg::KEY_W-1:0]   r_key;

    // Search and sweep.
    logic [CNT_W-1:0]            r_scan_idx;
    logic                        r_cmp_vld;
    logic [IDX_W-1:0]            r_cmp_idx;
    logic [ID_W-1:0]             r_id_rd;
    logic [mtd_pkg::KEY_W-1:0]   r_key_rd;
    logic                        scan_issue;

    // Key table write port.
    logic                        key_we;
    logic [IDX_W-1:0]            key_waddr;
    logic [mtd_pkg::KEY_W-1:0]   key_wdata;

    // Result staging and output register.
    mtd_pkg::t_status            r_res_code;
    logic                        r_res_match;
    logic                        r_out_vld;
    logic                        r_out_fwd;
    logic [mtd_pkg::STATUS_W-1:0] r_out_status;
    logic [mtd_pkg::SLOT_W-1:0]  r_out_mslot;
    logic [mtd_pkg::KEY_W-1:0]   r_out_key;

    logic [63:0]                 id_norm;
    logic                        id_alive;
    logic [SEL_W-1:0]            slot_wide;
    logic [SEL_W-1:0]            cmp_wide;
    logic                        price_ok_in;

    // The count saturates at the table size.
    always_comb begin
        cfg_ext        = CMP_W'(i_cfg_wdata);
        n_slots_in_use = (cfg_ext > SLOTS_CMP) ? SLOTS_CNT : cfg_ext[CNT_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slots_in_use <= '0;
        end else if (i_cfg_we) begin
            r_slots_in_use <= n_slots_in_use;
        end
    end

    // Keep the first ID_CHARS characters, up to the first zero byte.
    always_comb begin
        id_norm  = '0;
        id_alive = 1'b1;
        for (int i = 0; i < 8; i++) begin
            if (i >= ID_CHARS || i_instrument_id[8*i +: 8] == 8'h00) begin
                id_alive = 1'b0;
            end
            id_norm[8*i +: 8] = id_alive ? i_instrument_id[8*i +: 8] : 8'h00;
        end
    end

    assign slot_wide   = {{IDX_W{1'b0}}, i_slot};
    assign price_ok_in = (i_trade_price > 48'sd0)
                      && !((i_upper_limit > 48'sd0) && (i_trade_price > i_upper_limit))
                      && !((i_lower_limit > 48'sd0) && (i_trade_price < i_lower_limit));

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_mode     <= i_mode;
            r_id_norm  <= id_norm[ID_W-1:0];
            r_slot_ok  <= (slot_wide < SLOTS_SEL);
            r_slot_idx <= slot_wide[IDX_W-1:0];
            r_price_ok <= price_ok_in;
            // Colons at bytes 2 and 5 take no part in the key.
            r_term_hh  <= char_term(i_time_text[7:0],   mtd_pkg::W_HOUR_TENS)
                        + char_term(i_time_text[15:8],  mtd_pkg::W_HOUR);
            r_term_mm  <= char_term(i_time_text[31:24], mtd_pkg::W_MIN_TENS)
                        + char_term(i_time_text[39:32], mtd_pkg::W_MIN);
            r_term_ss  <= char_term(i_time_text[55:48], mtd_pkg::W_SEC_TENS)
                        + char_term(i_time_text[63:56], mtd_pkg::W_SEC);
            r_ms       <= i_millisecond;
        end
        r_key <= r_term_hh + r_term_mm + r_term_ss + mtd_pkg::KEY_W'(r_ms);
    end

    // Slot counter shared by the search and the key clearing sweeps.
    assign scan_issue = i_cmd.scan_step && (r_scan_idx < r_slots_in_use);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_idx <= '0;
            r_cmp_vld  <= 1'b0;
        end else if (i_cmd.accept) begin
            r_scan_idx <= '0;
            r_cmp_vld  <= 1'b0;
        end else if (i_cmd.scan_step) begin
            r_cmp_vld <= scan_issue;
            if (scan_issue) begin
                r_scan_idx <= r_scan_idx + 1'b1;
            end
        end else if (i_cmd.zero_step) begin
            r_scan_idx <= r_scan_idx + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (scan_issue) begin
            r_cmp_idx <= r_scan_idx[IDX_W-1:0];
        end
    end

    // Instrument table: one write port for loads, one read port for the search.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_write && r_slot_ok) begin
            id_mem[r_slot_idx] <= r_id_norm;
        end
        if (scan_issue) begin
            r_id_rd <= id_mem[r_scan_idx[IDX_W-1:0]];
        end
    end

    always_comb begin
        key_we    = 1'b0;
        key_waddr = r_cmp_idx;
        key_wdata = '0;
        if (i_cmd.load_write) begin
            key_we    = r_slot_ok;
            key_waddr = r_slot_idx;
        end else if (i_cmd.zero_step) begin
            key_we    = 1'b1;
            key_waddr = r_scan_idx[IDX_W-1:0];
        end else if (i_cmd.key_update) begin
            key_we    = 1'b1;
            key_wdata = r_key;
        end
    end

    // Last-seen key table, read at the matched slot.
    always_ff @(posedge i_clk) begin
        if (key_we) begin
            key_mem[key_waddr] <= key_wdata;
        end
        r_key_rd <= key_mem[r_cmp_idx];
    end

    always_comb begin
        o_stat.price_ok      = r_price_ok;
        o_stat.hit           = r_cmp_vld && (r_id_rd == r_id_norm);
        o_stat.scan_over     = !r_cmp_vld && (r_scan_idx >= r_slots_in_use);
        o_stat.zero_over_n   = (r_scan_idx >= r_slots_in_use);
        o_stat.zero_over_all = (r_scan_idx == SLOTS_CNT);
        o_stat.stale         = (r_key != '0) && ($signed(r_key) <= $signed(r_key_rd));
        o_stat.out_free      = !r_out_vld || i_out_ready;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.res_set) begin
            r_res_code  <= i_cmd.res_code;
            r_res_match <= i_cmd.res_match;
        end
    end

    assign cmp_wide = {{mtd_pkg::SLOT_W{1'b0}}, r_cmp_idx};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_fwd    <= (r_res_code == mtd_pkg::ST_FORWARDED);
            r_out_status <= r_res_code;
            r_out_mslot  <= r_res_match ? cmp_wide[mtd_pkg::SLOT_W-1:0] : '0;
            r_out_key    <= (r_mode == mtd_pkg::MODE_TICK) ? r_key : '0;
        end
    end

    assign o_out_valid    = r_out_vld;
    assign o_forwarded    = r_out_fwd;
    assign o_status       = r_out_status;
    assign o_matched_slot = r_out_mslot;
    assign o_time_key     = $signed(r_out_key);

endmodule
